// ===== sv/rtpl_pkg.sv =====
`default_nettype none
package rtpl_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned ENTRY_COUNT_W = 5;
  localparam int unsigned IN_DATA_W     = 136;
  localparam int unsigned OUT_DATA_W    = 40;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NOPOS   = 3'd2,
    ST_PERM    = 3'd3,
    ST_NOROUTE = 3'd4
  } status_t;

  // one stored route
  typedef struct packed {
    logic              fixed;
    logic [ADDR_W-1:0] hop;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] net;
  } entry_t;

  // flags from the shared comparator
  typedef struct packed {
    logic eq;
    logic ge;
  } cmp_res_t;

endpackage
`default_nettype wire

// ===== sv/rtpl_store.sv =====
`default_nettype none
module rtpl_store
  import rtpl_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/rtpl_cmp.sv =====
`default_nettype none
module rtpl_cmp
  import rtpl_pkg::*;
(
  input  wire logic [ADDR_W-1:0] a,
  input  wire logic [ADDR_W-1:0] b,
  output cmp_res_t               res
);

  // unsigned equality and greater-or-equal on one operand pair
  always_comb begin
    res.eq = (a == b);
    res.ge = (a >= b);
  end

endmodule
`default_nettype wire

// ===== sv/route_table_prefix_lookup_unit.sv =====
// throughput: one operation at a time; the entry memory has a single read port, so each
//   visited entry takes a read step, then a compare or move step
// reset: rst clears the route count, the sequencer and the output valid; entry memory
//   contents are not cleared
`default_nettype none
module route_table_prefix_lookup_unit
  import rtpl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata, low to high: route_net[31:0], route_mask[63:32], route_next_hop[95:64],
  //   route_permanent[96], position[101:97], dest_addr[133:102], zero pad[135:134]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: op[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata, low to high: next_hop[31:0], entry_count[36:32], zero pad[39:37]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: status[2:0]
  output logic [2:0]                 m_axis_tuser
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_CMP = 8'b0000_0100,
    S_CHK_RD   = 8'b0000_1000,
    S_CHK      = 8'b0001_0000,
    S_MOVE_RD  = 8'b0010_0000,
    S_MOVE_WR  = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // request held for the whole operation
  op_t               req_op;
  logic [ADDR_W-1:0] req_net;
  logic [ADDR_W-1:0] req_mask;
  logic [ADDR_W-1:0] req_hop;
  logic              req_perm;
  logic [ADDR_W-1:0] req_dest;

  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     slot;
  logic              put_pend;   // insert: slot write still owed after the shift

  status_t           res_status;
  logic [ADDR_W-1:0] res_hop;

  // input beat unpacked
  logic [ADDR_W-1:0] in_net;
  logic [ADDR_W-1:0] in_mask;
  logic [ADDR_W-1:0] in_hop;
  logic              in_perm;
  logic [POS_W-1:0]  in_pos;
  logic [ADDR_W-1:0] in_dest;
  op_t               in_op;
  logic              in_fire;
  logic              out_load;
  logic              pos_bad;

  assign in_net  = s_axis_tdata[31:0];
  assign in_mask = s_axis_tdata[63:32];
  assign in_hop  = s_axis_tdata[95:64];
  assign in_perm = s_axis_tdata[96];
  assign in_pos  = s_axis_tdata[101:97];
  assign in_dest = s_axis_tdata[133:102];
  assign in_op   = op_t'(s_axis_tuser);

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign pos_bad       = (in_pos == '0) || (PW'(in_pos) > PW'(count));

  // entry memory
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic [CW-1:0] move_src;
  logic          is_lookup;
  logic          is_insert;

  assign is_lookup = (req_op == OP_LOOKUP);
  assign is_insert = (req_op == OP_INSERT);

  // insert shifts entries up (read below, write above), remove shifts them down
  assign move_src = is_insert ? (idx - CW'(1)) : (idx + CW'(1));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    unique case (state)
      S_SCAN_RD: rd_en = (idx != count);
      S_CHK_RD:  rd_en = 1'b1;
      S_MOVE_RD: begin
        rd_en   = 1'b1;
        rd_addr = move_src[AW-1:0];
      end
      default: rd_en = 1'b0;
    endcase
  end

  // slot write of the new route reuses the move-read cycle once the shift has reached it
  logic put_now;
  assign put_now = (state == S_MOVE_RD) && is_insert && (idx == slot);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    if (state == S_MOVE_WR) begin
      wr_en = 1'b1;
    end else if (put_now && put_pend) begin
      wr_en         = 1'b1;
      wr_addr       = slot[AW-1:0];
      wr_data.net   = req_net;
      wr_data.mask  = req_mask;
      wr_data.hop   = req_hop;
      wr_data.fixed = req_perm;
    end
  end

  rtpl_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared comparator: lookup tests masked destination against the network,
  // insert tests the stored mask against the new mask
  logic [ADDR_W-1:0] cmp_a;
  logic [ADDR_W-1:0] cmp_b;
  cmp_res_t          cmp_res;
  logic              advance;

  assign cmp_a   = is_lookup ? (rd_data.mask & req_dest) : rd_data.mask;
  assign cmp_b   = is_lookup ? rd_data.net : req_mask;
  assign advance = is_lookup ? !cmp_res.eq : (rd_data.fixed || cmp_res.ge);

  rtpl_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          priority case (in_op)
            OP_INSERT: begin
              if (count == CW'(TABLE_DEPTH)) state_next = S_DONE;
              else if (in_perm)              state_next = S_MOVE_RD;
              else                           state_next = S_SCAN_RD;
            end
            OP_REMOVE: state_next = pos_bad ? S_DONE : S_CHK_RD;
            OP_LOOKUP: state_next = S_SCAN_RD;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (idx == count) state_next = is_lookup ? S_DONE : S_MOVE_RD;
        else              state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (advance)        state_next = S_SCAN_RD;
        else if (is_lookup) state_next = S_DONE;
        else                state_next = S_MOVE_RD;
      end
      S_CHK_RD: state_next = S_CHK;
      S_CHK:    state_next = rd_data.fixed ? S_DONE : S_MOVE_RD;
      S_MOVE_RD: begin
        if (put_now)                                 state_next = S_DONE;
        else if (!is_insert && (idx + CW'(1) == count)) state_next = S_DONE;
        else                                         state_next = S_MOVE_WR;
      end
      S_MOVE_WR: state_next = S_MOVE_RD;
      S_DONE:    state_next = out_load ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op   <= in_op;
      req_net  <= in_net;
      req_mask <= in_mask;
      req_hop  <= in_hop;
      req_perm <= in_perm;
      req_dest <= in_dest;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      idx        <= '0;
      slot       <= '0;
      put_pend   <= 1'b0;
      res_status <= ST_OK;
      res_hop    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_status <= ST_OK;
            res_hop    <= '0;
            idx        <= '0;
            slot       <= '0;
            put_pend   <= 1'b0;
            priority case (in_op)
              OP_INSERT: begin
                if (count == CW'(TABLE_DEPTH)) begin
                  res_status <= ST_FULL;
                end else if (in_perm) begin
                  idx      <= count;
                  put_pend <= 1'b1;
                end
              end
              OP_REMOVE: begin
                if (pos_bad) res_status <= ST_NOPOS;
                else         idx        <= CW'(in_pos - POS_W'(1));
              end
              default: ;
            endcase
          end
        end
        S_SCAN_RD: begin
          if (idx == count) begin
            if (is_lookup) begin
              res_status <= ST_NOROUTE;
            end else begin
              slot     <= idx;
              put_pend <= 1'b1;
            end
          end
        end
        S_SCAN_CMP: begin
          if (advance) begin
            idx <= idx + CW'(1);
          end else if (is_lookup) begin
            res_hop <= rd_data.hop;
          end else begin
            slot     <= idx;
            idx      <= count;
            put_pend <= 1'b1;
          end
        end
        S_CHK: begin
          if (rd_data.fixed) res_status <= ST_PERM;
        end
        S_MOVE_RD: begin
          if (put_now) begin
            count    <= count + CW'(1);
            put_pend <= 1'b0;
          end else if (!is_insert && (idx + CW'(1) == count)) begin
            count <= count - CW'(1);
          end
        end
        S_MOVE_WR: idx <= move_src;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {3'b000, ENTRY_COUNT_W'(count), res_hop};
      m_axis_tuser <= res_status;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("route count above table depth");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_MOVE_WR || state == S_MOVE_RD))
    else $error("entry write outside a move step");

  a_put_counts: assert property (@(posedge clk) disable iff (rst)
    (put_now && put_pend) |=> count == CW'($past(count) + CW'(1)))
    else $error("insert did not bump the route count");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    out_load |=> state == S_IDLE && m_axis_tvalid)
    else $error("result load did not return to idle");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("accepted a beat without going busy");

endmodule
`default_nettype wire
